// ===== design/tvnm_pkg.sv =====
package tvnm_pkg;

  // Table depth and feature positions
  localparam int MAX_ITEMS = 64;
  localparam int FEATURES  = 32;

  // Fixed field widths
  localparam int MASK_W    = 32;
  localparam int FIELD_W   = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  // Derived widths
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_CNT = 1'b1;

  localparam logic [CFG_W-1:0] MAX_DIFF_RESET = 6'd0;
  localparam logic [CFG_W-1:0] FEAT_CNT_RESET = 6'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DROP
  } state_e;

  // Read request to the vector store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } store_rd_t;

  // One stored vector
  typedef struct packed {
    logic [MASK_W-1:0] known;
    logic [MASK_W-1:0] yes;
  } vec_t;

  // Low feature positions in use, limited by FEATURES and the mask width
  function automatic logic [MASK_W-1:0] in_use_mask(input logic [CFG_W-1:0] fc);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int b = 0; b < MASK_W; b++) begin
      m[b] = (b < int'(fc)) && (b < FEATURES);
    end
    return m;
  endfunction

  // Population count as nibble counts followed by a short sum
  function automatic logic [FIELD_W-1:0] count_ones(input logic [MASK_W-1:0] v);
    logic [2:0]         nib;
    logic [FIELD_W-1:0] total;
    total = '0;
    for (int n = 0; n < MASK_W / 4; n++) begin
      nib = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
      total = total + FIELD_W'(nib);
    end
    return total;
  endfunction

endpackage

// ===== design/tvnm_store.sv =====
module tvnm_store (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [tvnm_pkg::IDX_W-1:0] wr_addr_i,
  input  tvnm_pkg::vec_t      wr_data_i,
  input  tvnm_pkg::store_rd_t rd_i,
  output tvnm_pkg::vec_t      rd_data_o
);
  import tvnm_pkg::*;

  vec_t mem_q [MAX_ITEMS];
  vec_t rd_data_q;

  // Write the arriving vector
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, held while the scan is stalled
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/tvnm_cmp.sv =====
module tvnm_cmp (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  tvnm_pkg::vec_t                  cur_i,
  input  tvnm_pkg::vec_t                  stored_i,
  input  logic [tvnm_pkg::MASK_W-1:0]     use_i,
  output logic [tvnm_pkg::FIELD_W-1:0]    diff_cnt_o
);
  import tvnm_pkg::*;

  logic [MASK_W-1:0]  diff;
  logic [FIELD_W-1:0] cnt_q;

  // Positions in use, known in both, disagreeing
  assign diff = cur_i.known & stored_i.known & (cur_i.yes ^ stored_i.yes) & use_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cnt_q <= count_ones(diff);
    end
  end

  assign diff_cnt_o = cnt_q;

endmodule

// ===== design/ternary_vector_near_match_finder.sv =====
// Each earlier vector is read, counted in the compare register and, on a match, held as the
//   pending pair until the next match or the flush moves it to the output register; a
//   dropped result comes from the drop state. One compared vector per cycle unless the output
//   stalls, which freezes the scan; the next input is taken once the last result is registered.
// Reset clears the stored count and restores max_differences 0 and feature_count 32;
//   stored vectors are not cleared and are only read after being written.
module ternary_vector_near_match_finder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [tvnm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tvnm_pkg::CFG_W-1:0]        cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              new_set_i,
  input  logic [tvnm_pkg::MASK_W-1:0]       known_mask_i,
  input  logic [tvnm_pkg::MASK_W-1:0]       yes_mask_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tvnm_pkg::FIELD_W-1:0]      earlier_index_o,
  output logic [tvnm_pkg::FIELD_W-1:0]      current_index_o,
  output logic [tvnm_pkg::FIELD_W-1:0]      difference_count_o,
  output logic                              dropped_o,
  output logic                              last_of_run_o
);
  import tvnm_pkg::*;

  state_e state_q, state_d;

  logic [CFG_W-1:0]   max_diff_q, feat_cnt_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic               v1_q, v1_d, v2_q, v2_d;
  logic [IDX_W-1:0]   idx1_q, idx1_d, idx2_q, idx2_d;
  logic               pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic [FIELD_W-1:0] pend_cnt_q, pend_cnt_d;
  vec_t               cur_q, cur_d;

  logic               out_valid_q, out_valid_d;
  logic [FIELD_W-1:0] out_earlier_q, out_earlier_d;
  logic [FIELD_W-1:0] out_current_q, out_current_d;
  logic [FIELD_W-1:0] out_cnt_q, out_cnt_d;
  logic               out_drop_q, out_drop_d;
  logic               out_last_q, out_last_d;

  logic               in_xfer, adv, issue_more, match;
  logic [CNT_W-1:0]   base;
  logic               wr_en;
  vec_t               in_vec;
  store_rd_t          rd;
  vec_t               rd_data;
  logic [MASK_W-1:0]  use_mask;
  logic [FIELD_W-1:0] diff_cnt;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign adv        = !out_valid_q || !out_stall_i;
  assign base       = new_set_i ? '0 : count_q;
  assign issue_more = (issue_q < CNT_W'(pos_q));
  assign use_mask   = in_use_mask(feat_cnt_q);
  assign match      = v2_q && (diff_cnt <= max_diff_q);
  assign wr_en      = in_xfer && (base != CNT_W'(MAX_ITEMS));
  assign in_vec     = '{known: known_mask_i, yes: yes_mask_i};

  assign rd.en   = adv && (state_q == ST_SCAN);
  assign rd.addr = issue_q[IDX_W-1:0];

  tvnm_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (base[IDX_W-1:0]),
    .wr_data_i (in_vec),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  tvnm_cmp u_cmp (
    .clk_i      (clk_i),
    .en_i       (rd.en),
    .cur_i      (cur_q),
    .stored_i   (rd_data),
    .use_i      (use_mask),
    .diff_cnt_o (diff_cnt)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_diff_q <= MAX_DIFF_RESET;
      feat_cnt_q <= FEAT_CNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_DIFF: max_diff_q <= cfg_data_i;
        CFG_FEAT_CNT: feat_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: next state, scan pipeline, pending pair and output register
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    pos_d         = pos_q;
    issue_d       = issue_q;
    v1_d          = v1_q;
    v2_d          = v2_q;
    idx1_d        = idx1_q;
    idx2_d        = idx2_q;
    pend_valid_d  = pend_valid_q;
    pend_idx_d    = pend_idx_q;
    pend_cnt_d    = pend_cnt_q;
    cur_d         = cur_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_earlier_d = out_earlier_q;
    out_current_d = out_current_q;
    out_cnt_d     = out_cnt_q;
    out_drop_d    = out_drop_q;
    out_last_d    = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cur_d        = in_vec;
          pend_valid_d = 1'b0;
          v1_d         = 1'b0;
          v2_d         = 1'b0;
          issue_d      = '0;
          if (base == CNT_W'(MAX_ITEMS)) begin
            count_d = base;
            state_d = ST_DROP;
          end else begin
            pos_d   = base[IDX_W-1:0];
            count_d = base + CNT_W'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (adv) begin
          // advance the read, compare and decide stages together
          v1_d   = issue_more;
          idx1_d = issue_q[IDX_W-1:0];
          if (issue_more) begin
            issue_d = issue_q + CNT_W'(1);
          end
          v2_d   = v1_q;
          idx2_d = idx1_q;
          if (match) begin
            if (pend_valid_q) begin
              out_valid_d   = 1'b1;
              out_earlier_d = FIELD_W'(pend_idx_q);
              out_current_d = FIELD_W'(pos_q);
              out_cnt_d     = pend_cnt_q;
              out_drop_d    = 1'b0;
              out_last_d    = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_idx_d   = idx2_q;
            pend_cnt_d   = diff_cnt;
          end
        end
        if (!issue_more && !v1_q && !v2_q) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (adv) begin
          out_valid_d   = 1'b1;
          out_earlier_d = FIELD_W'(pend_idx_q);
          out_current_d = FIELD_W'(pos_q);
          out_cnt_d     = pend_cnt_q;
          out_drop_d    = 1'b0;
          out_last_d    = 1'b1;
          pend_valid_d  = 1'b0;
          state_d       = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (adv) begin
          out_valid_d   = 1'b1;
          out_earlier_d = '0;
          out_current_d = '0;
          out_cnt_d     = '0;
          out_drop_d    = 1'b1;
          out_last_d    = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      v1_q         <= v1_d;
      v2_q         <= v2_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q         <= pos_d;
    issue_q       <= issue_d;
    idx1_q        <= idx1_d;
    idx2_q        <= idx2_d;
    pend_idx_q    <= pend_idx_d;
    pend_cnt_q    <= pend_cnt_d;
    cur_q         <= cur_d;
    out_earlier_q <= out_earlier_d;
    out_current_q <= out_current_d;
    out_cnt_q     <= out_cnt_d;
    out_drop_q    <= out_drop_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o        = out_valid_q;
  assign earlier_index_o    = out_earlier_q;
  assign current_index_o    = out_current_q;
  assign difference_count_o = out_cnt_q;
  assign dropped_o          = out_drop_q;
  assign last_of_run_o      = out_last_q;

  // Ready for a new item only with the scan pipeline and pending pair empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!v1_q && !v2_q && !pend_valid_q))
    else $error("idle with scan work outstanding");

  // Stored count stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("stored count beyond table depth");

  // A dropped result always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_drop_q) |-> out_last_q)
    else $error("dropped result not marked last");

  // Scan freezes while the output register is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && out_valid_q && out_stall_i) |=> $stable(issue_q))
    else $error("scan advanced under output stall");

endmodule

// ===== sim/tb_ternary_vector_near_match_finder.sv =====
`timescale 1ns / 1ps

module tb_ternary_vector_near_match_finder;
  import tvnm_pkg::*;

  localparam int DRAIN_CYCLES = MAX_ITEMS + 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;

  // One reported pair, or a dropped-vector notice
  typedef struct packed {
    logic [FIELD_W-1:0] earlier;
    logic [FIELD_W-1:0] current;
    logic [FIELD_W-1:0] diffs;
    logic               dropped;
    logic               last;
  } pair_t;

  // Mirror of the vector table; predicts the pairs each vector produces
  class near_match_board;
    logic [MASK_W-1:0]  known_tab [MAX_ITEMS];
    logic [MASK_W-1:0]  yes_tab   [MAX_ITEMS];
    int unsigned        fill;
    logic [CFG_W-1:0]   max_diff;
    logic [CFG_W-1:0]   feat_cnt;
    pair_t              pending_q [$];
    int                 errors;
    int                 vectors;
    int                 pairs_seen;
    int                 drops_seen;

    function new();
      fill       = 0;
      max_diff   = MAX_DIFF_RESET;
      feat_cnt   = FEAT_CNT_RESET;
      errors     = 0;
      vectors    = 0;
      pairs_seen = 0;
      drops_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_MAX_DIFF: max_diff = val;
        CFG_FEAT_CNT: feat_cnt = val;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    // Append one predicted result
    function void add_pair(pair_t p);
      pending_q = {pending_q, p};
    endfunction

    // Note an accepted vector and queue the pairs it should report
    function void note_vector(bit ns, logic [MASK_W-1:0] k, logic [MASK_W-1:0] y);
      logic [MASK_W-1:0] use_bits;
      int                lim;
      int                ones;
      int                emitted;
      pair_t             p;
      vectors++;
      lim = (int'(feat_cnt) > FEATURES) ? FEATURES : int'(feat_cnt);
      use_bits = (lim >= MASK_W) ? '1 : ((32'd1 << lim) - 32'd1);
      if (ns) fill = 0;
      // Full table: discard the vector, report one drop
      if (fill >= MAX_ITEMS) begin
        p = '{earlier: '0, current: '0, diffs: '0, dropped: 1'b1, last: 1'b1};
        add_pair(p);
        return;
      end
      emitted = 0;
      for (int i = 0; i < int'(fill); i++) begin
        ones = $countones(k & known_tab[i] & (y ^ yes_tab[i]) & use_bits);
        if (ones <= int'(max_diff)) begin
          p = '{earlier: FIELD_W'(i), current: FIELD_W'(fill), diffs: FIELD_W'(ones),
                dropped: 1'b0, last: 1'b0};
          add_pair(p);
          emitted++;
        end
      end
      // Flag the final pair of this vector
      if (emitted > 0) begin
        p = pending_q.pop_back();
        p.last = 1'b1;
        add_pair(p);
      end
      known_tab[fill] = k;
      yes_tab[fill]   = y;
      fill++;
    endfunction

    function void compare_field(string name, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    // Check one accepted result against the oldest prediction
    function void check_result(pair_t got);
      pair_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d/%0b/%0b",
                 $time, got.earlier, got.current, got.diffs, got.dropped, got.last);
        return;
      end
      want = pending_q.pop_front();
      if (want.dropped) drops_seen++;
      else pairs_seen++;
      compare_field("earlier_index", want.earlier, got.earlier);
      compare_field("current_index", want.current, got.current);
      compare_field("difference_count", want.diffs, got.diffs);
      compare_field("dropped", FIELD_W'(want.dropped), FIELD_W'(got.dropped));
      compare_field("last_of_run", FIELD_W'(want.last), FIELD_W'(got.last));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_stall_o;
  logic                  new_set;
  logic [MASK_W-1:0]     known_mask;
  logic [MASK_W-1:0]     yes_mask;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [FIELD_W-1:0]    earlier_index_o;
  logic [FIELD_W-1:0]    current_index_o;
  logic [FIELD_W-1:0]    difference_count_o;
  logic                  dropped_o;
  logic                  last_of_run_o;

  near_match_board board;
  bit                  calm;
  bit                  hold_request;
  int                  hold_left;
  int                  hold_at;
  int                  quiet_cycles;
  int                  settings_used;

  ternary_vector_near_match_finder uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .new_set_i          (new_set),
    .known_mask_i       (known_mask),
    .yes_mask_i         (yes_mask),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .earlier_index_o    (earlier_index_o),
    .current_index_o    (current_index_o),
    .difference_count_o (difference_count_o),
    .dropped_o          (dropped_o),
    .last_of_run_o      (last_of_run_o)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = !calm && ($urandom_range(0, 99) < 25);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    pair_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{earlier_index_o, current_index_o, difference_count_o, dropped_o, last_of_run_o};
      board.check_result(got);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one vector and hold it until the transfer
  task automatic send_vector(bit ns, logic [MASK_W-1:0] k, logic [MASK_W-1:0] y);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid   = 1'b1;
    new_set    = ns;
    known_mask = k;
    yes_mask   = y;
    do @(posedge clk_i); while (in_stall_o);
    board.note_vector(ns, k, y);
  endtask

  // Drop valid and wait until every prediction has been met, then let the scan finish
  task automatic settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic configure(logic [CFG_W-1:0] md, logic [CFG_W-1:0] fc);
    settle();
    write_reg(CFG_MAX_DIFF, md);
    write_reg(CFG_FEAT_CNT, fc);
    settings_used++;
  endtask

  // Random sets of similar vectors, with some noise and stray set restarts
  task automatic run_phase(logic [CFG_W-1:0] md, logic [CFG_W-1:0] fc, int n_items,
                           int min_len, int max_len);
    int                set_left;
    bit                ns;
    logic [MASK_W-1:0] base_k;
    logic [MASK_W-1:0] base_y;
    logic [MASK_W-1:0] k;
    logic [MASK_W-1:0] y;
    configure(md, fc);
    set_left = 0;
    base_k   = '0;
    base_y   = '0;
    for (int n = 0; n < n_items; n++) begin
      ns = (set_left == 0);
      if (ns) begin
        set_left = $urandom_range(min_len, max_len);
        base_k   = $urandom | $urandom;
        base_y   = $urandom;
      end
      set_left--;
      if (max_len < MAX_ITEMS && $urandom_range(0, 19) == 0) ns = 1'b1;
      case ($urandom_range(0, 7))
        0: begin
          k = $urandom;
          y = $urandom;
        end
        1: begin
          k = base_k;
          y = base_y;
        end
        default: begin
          k = base_k ^ ($urandom & $urandom & $urandom);
          y = base_y ^ ($urandom & $urandom & $urandom & $urandom);
        end
      endcase
      send_vector(ns, k, y);
    end
  endtask

  initial begin
    board         = new();
    calm          = 1'b0;
    hold_request  = 1'b0;
    hold_at       = 0;
    quiet_cycles  = 0;
    settings_used = 1;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MAX_DIFF;
    cfg_data      = '0;
    in_valid      = 1'b0;
    new_set       = 1'b0;
    known_mask    = '0;
    yes_mask      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: exact matches only, all positions in use
    send_vector(1'b1, 32'h0000_0000, 32'h0000_0000);
    send_vector(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vector(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_vector(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_vector(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_vector(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);

    // Widest threshold: fully opposed vectors still pair
    configure(6'd32, 6'd32);
    send_vector(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_vector(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vector(1'b0, 32'h5555_5555, 32'h0000_0000);

    // No positions in use: every count is zero
    configure(6'd63, 6'd0);
    send_vector(1'b1, 32'hFFFF_FFFF, 32'h1234_5678);
    send_vector(1'b0, 32'hFFFF_FFFF, 32'hEDCB_A987);
    send_vector(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Oversized feature count saturates; last vector finds no pair
    configure(6'd1, 6'd63);
    send_vector(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_vector(1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_vector(1'b0, 32'hFFFF_FFFF, 32'h0000_0003);

    // Single position in use, unknowns never differ
    configure(6'd0, 6'd1);
    send_vector(1'b1, 32'h0000_0001, 32'h0000_0001);
    send_vector(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_vector(1'b0, 32'hFFFF_FFFE, 32'h0000_0000);

    // Random sets across several settings
    run_phase(6'd2, 6'd32, 70, 1, 12);
    run_phase(6'd32, 6'd32, 40, 1, 10);
    run_phase(6'd63, 6'd0, 30, 1, 8);
    calm = 1'b1;
    run_phase(6'd5, 6'd63, 60, 4, 16);
    calm = 1'b0;
    run_phase(6'd1, 6'd1, 30, 1, 8);

    // Long receiver hold-off once vectors of this phase are flowing
    hold_at = board.vectors + 3;
    fork
      run_phase(6'd4, 6'd17, 50, 4, 20);
      begin
        while (board.vectors < hold_at) @(posedge clk_i);
        hold_request = 1'b1;
      end
    join

    // Fill the table and overflow it, then continue with fresh sets
    run_phase(6'd0, 6'd8, MAX_ITEMS + 6, MAX_ITEMS + 6, MAX_ITEMS + 6);
    send_vector(1'b0, $urandom, $urandom);
    send_vector(1'b1, $urandom, $urandom);
    run_phase(6'd3, 6'd32, 20, 1, 8);

    settle();
    $display("Covered %0d vectors under %0d register settings", board.vectors, settings_used);
    $display("Checked %0d pair results and %0d dropped-vector results",
             board.pairs_seen, board.drops_seen);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
